@@ rtl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the base64url stream decoder
// Character codes, the sextet lookup and the command word that the
// front end passes to the result sequencer.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int COUNT_W     = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UNDER = 8'h5F;  // '_'

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // One decoded group, as many as three bytes, plus the string end flag.
  typedef struct packed {
    logic [2:0][7:0]      data;
    logic [1:0]           n_bytes;
    logic [COUNT_W-1:0]   base_count;
    logic                 fin;
  } grp_cmd_t;

  // Map a text byte to its 6-bit value; valid is low outside the alphabet.
  function automatic sextet_t sextet_of(logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
      s.value = 6'd62;
    end else if (c == CHAR_SLASH || c == CHAR_UNDER) begin
      s.value = 6'd63;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/b64d_if.sv @@
// ----------------------------------------------------------------------------
// b64d_if: word channels of the base64url stream decoder
// Valid/ready channels for input characters and decoded results.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink   (input valid, input character, input final_char, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_run;
  logic       end_of_string;
  logic [9:0] total_bytes;

  modport source (output valid, output data_byte, output byte_valid, output end_of_run,
                  output end_of_string, output total_bytes, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input end_of_run,
                  input end_of_string, input total_bytes, output ready);
  modport mon    (input valid, input data_byte, input byte_valid, input end_of_run,
                  input end_of_string, input total_bytes, input ready);
endinterface

@@ rtl/base64url_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base64url_stream_decoder: streaming base64 / base64url decoder
// Character intake, group command queue and result sequencer.
// ----------------------------------------------------------------------------
// Takes one text character per word on in_ch, with final_char on the last
// character of a string, and returns decoded bytes on out_ch. Both the
// standard and the URL-safe alphabet are understood ('+'/'-' give 62,
// '/'/'_' give 63). Characters fill groups of four slots; a character outside
// the alphabet (zero byte included) takes a slot but adds no bits, and '='
// closes its group at once while the remaining slots are passed over. A group
// with k valid characters (k >= 2) gives k-1 bytes. Bytes past the limit
// min(max_output_bytes, MAX_OUT_BYTES) are dropped and not counted. The final
// character always gives at least one result word carrying the string's
// byte total; with no byte it is a word with byte_valid low.
// Rate: the intake takes one character every cycle while the four-entry
// command queue has room, so characters stream in back to back. The result
// sequencer sends one word per cycle unless the output is stalled, so a
// character that closes a group of n bytes gives n result words. An accepted
// character's command is registered in the queue, and its first result word
// then passes through the output register.
// Register map (APB, 32-bit data): offset 0x0 max_output_bytes [9:0],
// reset 512. Write it only while the block is idle.
// ----------------------------------------------------------------------------
module base64url_stream_decoder #(
  parameter int MAX_OUT_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [b64d_pkg::COUNT_W-1:0] max_output_bytes_r;
  logic [b64d_pkg::COUNT_W-1:0] limit;
  logic                         cfg_wr;
  logic                         push;
  logic                         pop;
  logic                         q_full;
  logic                         q_empty;
  b64d_pkg::grp_cmd_t           push_cmd;
  b64d_pkg::grp_cmd_t           head;

  // Configuration: a single register at word 0, upper word decodes to nothing.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {22'd0, max_output_bytes_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_output_bytes_r <= 10'd512;
    end else if (cfg_wr) begin
      max_output_bytes_r <= pwdata[b64d_pkg::COUNT_W-1:0];
    end
  end

  // Clamp the programmed limit by the build-time ceiling.
  assign limit = (32'(max_output_bytes_r) > 32'(MAX_OUT_BYTES))
                 ? b64d_pkg::COUNT_W'(MAX_OUT_BYTES) : max_output_bytes_r;

  // Front end: accept characters, assemble groups, push commands.
  b64d_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .limit  (limit),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  // Decouple intake from result delivery.
  b64d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: expand commands into result words.
  b64d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/b64d_front.sv @@
// ----------------------------------------------------------------------------
// b64d_front: character intake and group assembly
// Accepts one character a cycle unless the queue is full; tracks slots,
// padding and byte count; pushes a command per string end or group with bytes.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                         clk,
  input  logic                         rst_n,
  b64d_in_if.sink                      in_ch,
  input  logic [b64d_pkg::COUNT_W-1:0] limit,
  input  logic                         q_full,
  output logic                         push,
  output b64d_pkg::grp_cmd_t           cmd
);

  logic [23:0]                  bits_r;
  logic [1:0]                   slot_r;
  logic [2:0]                   valid_r;
  logic                         pad_seen_r;
  logic [b64d_pkg::COUNT_W-1:0] count_r;

  b64d_pkg::sextet_t            sx;
  logic                         acc;
  logic                         fin;
  logic                         is_pad;
  logic                         add;
  logic [23:0]                  bits_a;
  logic [2:0]                   v_a;
  logic [1:0]                   slot_n;
  logic                         wrap;
  logic                         close;
  logic [23:0]                  aligned;
  logic [1:0]                   nraw;
  logic [b64d_pkg::COUNT_W-1:0] room;
  logic [1:0]                   kept;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign fin         = in_ch.final_char;

  always_comb begin
    sx      = b64d_pkg::sextet_of(in_ch.character);
    is_pad  = !pad_seen_r && (in_ch.character == b64d_pkg::CHAR_PAD);
    add     = !pad_seen_r && !is_pad && sx.valid && (valid_r < 3'd4);
    bits_a  = add ? {bits_r[17:0], sx.value} : bits_r;
    v_a     = add ? valid_r + 3'd1 : valid_r;
    slot_n  = slot_r + 2'd1;
    wrap    = (slot_n == 2'd0);
    close   = is_pad || (!pad_seen_r && (wrap || fin));

    // top-align the collected bits so bytes come off the high end
    case (v_a)
      3'd2:    aligned = bits_a << 12;
      3'd3:    aligned = bits_a << 6;
      3'd4:    aligned = bits_a;
      default: aligned = 24'd0;
    endcase
    nraw = (close && v_a >= 3'd2) ? 2'(v_a - 3'd1) : 2'd0;

    room = (count_r < limit) ? limit - count_r : '0;
    kept = (room >= b64d_pkg::COUNT_W'(nraw)) ? nraw : room[1:0];

    cmd.data[0]    = aligned[23:16];
    cmd.data[1]    = aligned[15:8];
    cmd.data[2]    = aligned[7:0];
    cmd.n_bytes    = kept;
    cmd.base_count = count_r;
    cmd.fin        = fin;
    push           = acc && (kept != 2'd0 || fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r     <= '0;
      slot_r     <= '0;
      valid_r    <= '0;
      pad_seen_r <= 1'b0;
      count_r    <= '0;
    end else if (acc) begin
      if (fin || wrap) begin
        bits_r     <= '0;
        valid_r    <= '0;
        pad_seen_r <= 1'b0;
      end else if (is_pad) begin
        bits_r     <= '0;
        valid_r    <= '0;
        pad_seen_r <= 1'b1;
      end else begin
        bits_r  <= bits_a;
        valid_r <= v_a;
      end
      slot_r  <= fin ? 2'd0 : slot_n;
      count_r <= fin ? '0 : count_r + b64d_pkg::COUNT_W'(kept);
    end
  end

endmodule

@@ rtl/b64d_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_queue: command queue between intake and result sequencer
// Small register FIFO of group commands.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64d_pkg::grp_cmd_t push_cmd,
  input  logic               pop,
  output b64d_pkg::grp_cmd_t head,
  output logic               full,
  output logic               empty
);

  localparam int DEPTH = b64d_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64d_pkg::grp_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/b64d_back.sv @@
// ----------------------------------------------------------------------------
// b64d_back: result sequencer
// Expands each queued group command into result words, one a cycle while
// the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  b64d_pkg::grp_cmd_t head,
  output logic               pop,
  b64d_out_if.source         out_ch
);

  logic       out_valid_r;
  logic [7:0] data_r;
  logic       byte_valid_r;
  logic       eor_r;
  logic       eos_r;
  logic [9:0] total_r;
  logic [1:0] idx_r;

  logic       load;
  logic       empty_cmd;
  logic       last;
  logic [7:0] data_nxt;
  logic [9:0] total_nxt;
  logic [1:0] idx_nxt;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_byte     = data_r;
  assign out_ch.byte_valid    = byte_valid_r;
  assign out_ch.end_of_run    = eor_r;
  assign out_ch.end_of_string = eos_r;
  assign out_ch.total_bytes   = total_r;

  always_comb begin
    load      = !out_valid_r || out_ch.ready;
    empty_cmd = (head.n_bytes == 2'd0);
    last      = empty_cmd || (idx_r == head.n_bytes - 2'd1);
    case (idx_r)
      2'd0:    data_nxt = head.data[0];
      2'd1:    data_nxt = head.data[1];
      default: data_nxt = head.data[2];
    endcase
    if (empty_cmd) begin
      data_nxt  = 8'd0;
      total_nxt = head.base_count;
    end else begin
      total_nxt = head.base_count + 10'(idx_r) + 10'd1;
    end
    pop     = load && !q_empty && last;
    idx_nxt = last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= !q_empty;
      if (!q_empty) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      data_r       <= data_nxt;
      byte_valid_r <= !empty_cmd;
      eor_r        <= last;
      eos_r        <= last && head.fin;
      total_r      <= total_nxt;
    end
  end

endmodule

@@ rtl/b64d_checker.sv @@
// ----------------------------------------------------------------------------
// b64d_checker: port-level checks of the base64url stream decoder
// Watches the result channel and flags malformed result words.
// ----------------------------------------------------------------------------
module b64d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_byte_valid,
  input logic       out_end_of_run,
  input logic       out_end_of_string,
  input logic [9:0] out_total_bytes
);

  // Hold a stalled result word.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte)
      && $stable(out_total_bytes) && $stable(out_end_of_string))
    else $error("result word changed while stalled");

  // End of string always closes the run of its character.
  a_eos_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_string |-> out_end_of_run)
    else $error("end_of_string without end_of_run");

  // A word without a byte is only the empty string end.
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |->
      out_data_byte == 8'd0 && out_end_of_run && out_end_of_string)
    else $error("empty result word is not a string end");

  // A delivered byte is always counted.
  a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_total_bytes != 10'd0)
    else $error("decoded byte with zero total");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_data_byte     (out_ch.data_byte),
  .out_byte_valid    (out_ch.byte_valid),
  .out_end_of_run    (out_ch.end_of_run),
  .out_end_of_string (out_ch.end_of_string),
  .out_total_bytes   (out_ch.total_bytes)
);
